/* src/rtmm_pkg.sv */
// Shared constants, types and control structs for the row-times-matrix multiply core.
package rtmm_pkg;

	// Matrix dimension and derived index width
	localparam int DIM    = 4;
	localparam int IDX_W  = (DIM > 1) ? $clog2(DIM) : 1;

	// Field widths
	localparam int VAL_W       = 16;
	localparam int PROD_W      = 2 * VAL_W;
	localparam int SUM_W       = 36;
	localparam int COL_W       = 4;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 40;

	typedef logic [IDX_W-1:0] idx_t;

	// Input beat kinds carried on tuser
	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_ROW  = 1'b1
	} opcode_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic b_wr;     // write this cell's B column entry
		idx_t b_row;    // B row being written
		logic mul_en;   // A element present, form product
		idx_t mul_row;  // B row used by the product
		logic acc_en;   // add registered product into the sum
		logic shift;    // take the neighbor's sum (drain)
	} cell_ctl_t;

endpackage

/* src/row_times_matrix_multiply_core.sv */
// Top level: sequencer, load/row counters and the chain of column cells.
// A row's final A beat is registered into the product stage with its row-end flag;
// the accumulate then updates the sums and starts the drain, and the columns leave cell 0
// in order, column 0 first, one per beat while the sink is ready. One A or B beat per cycle
// inside a row; at row end the input stalls through the accumulate and the DIM output beats.
// Reset (arst_n low, asynchronous): counters, sums and handshake state clear; B holds
// no reset value and must be loaded before use.
module row_times_matrix_multiply_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [rtmm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [15:0] value
	input  logic [0:0]                           s_axis_tuser,  // [0] opcode
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [rtmm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [35:0] product_value, [39:36] column
	output logic                                 m_axis_tlast
);
	import rtmm_pkg::*;

	logic                    in_hs;
	logic                    out_hs;
	logic                    load_hs;
	logic                    row_hs;
	logic                    row_end;
	idx_t                    load_row_q;
	idx_t                    load_col_q;
	idx_t                    row_pos_q;
	logic                    valid_s1;
	logic                    last_s1;
	logic                    drain_q;
	idx_t                    cnt_q;
	logic signed [VAL_W-1:0] value;
	logic signed [SUM_W-1:0] sum_chain [DIM+1];
	cell_ctl_t               ctl [DIM];

	assign value   = $signed(s_axis_tdata[VAL_W-1:0]);
	assign in_hs   = s_axis_tvalid && s_axis_tready;
	assign out_hs  = m_axis_tvalid && m_axis_tready;
	assign load_hs = in_hs && (opcode_t'(s_axis_tuser[0]) == OP_LOAD);
	assign row_hs  = in_hs && (opcode_t'(s_axis_tuser[0]) == OP_ROW);
	assign row_end = row_hs && (row_pos_q == idx_t'(DIM - 1));

	// Input stalls while the row's last product settles and while the sums drain
	assign s_axis_tready = !drain_q && !(valid_s1 && last_s1);

	// B load position, row-major with wrap
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_row_q <= '0;
			load_col_q <= '0;
		end else if (load_hs) begin
			if (load_col_q == idx_t'(DIM - 1)) begin
				load_col_q <= '0;
				load_row_q <= (load_row_q == idx_t'(DIM - 1)) ? '0 : load_row_q + idx_t'(1);
			end else begin
				load_col_q <= load_col_q + idx_t'(1);
			end
		end
	end

	// Position within the current A row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q <= '0;
		end else if (row_hs) begin
			row_pos_q <= (row_pos_q == idx_t'(DIM - 1)) ? '0 : row_pos_q + idx_t'(1);
		end
	end

	// Product stage valid and row-end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= row_hs;
			last_s1  <= row_end;
		end
	end

	// Drain sequencer: column counter walks the sums out of cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			cnt_q   <= '0;
		end else if (valid_s1 && last_s1) begin
			drain_q <= 1'b1;
			cnt_q   <= '0;
		end else if (out_hs) begin
			cnt_q <= cnt_q + idx_t'(1);
			if (cnt_q == idx_t'(DIM - 1)) begin
				drain_q <= 1'b0;
			end
		end
	end

	// Cell chain; zeros enter at the far end so sums clear as they drain
	assign sum_chain[DIM] = '0;

	for (genvar c = 0; c < DIM; c++) begin : g_cell
		always_comb begin
			ctl[c].b_wr    = load_hs && (load_col_q == idx_t'(c));
			ctl[c].b_row   = load_row_q;
			ctl[c].mul_en  = row_hs;
			ctl[c].mul_row = row_pos_q;
			ctl[c].acc_en  = valid_s1;
			ctl[c].shift   = out_hs;
		end

		rtmm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[c]),
			.value   (value),
			.sum_in  (sum_chain[c+1]),
			.sum_out (sum_chain[c])
		);
	end

	// Output beat
	assign m_axis_tvalid = drain_q;
	assign m_axis_tdata  = {COL_W'(cnt_q), sum_chain[0]};
	assign m_axis_tlast  = (cnt_q == idx_t'(DIM - 1));

	// Checks
	a_no_in_during_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !s_axis_tready)
		else $error("input accepted while draining");

	a_drain_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_hs && m_axis_tlast) |=> !m_axis_tvalid)
		else $error("drain continued past last column");

	a_row_pos_clear_at_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drain_q) |-> (row_pos_q == '0) && (cnt_q == '0))
		else $error("row position or column count not clear at drain start");

	a_no_acc_during_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_hs |-> !valid_s1)
		else $error("accumulate and shift in same cycle");

endmodule

/* src/rtmm_cell.sv */
// One column cell: holds a column of B, a product stage and the column sum.
module rtmm_cell (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rtmm_pkg::cell_ctl_t                    ctl,
	input  logic signed [rtmm_pkg::VAL_W-1:0]      value,
	input  logic signed [rtmm_pkg::SUM_W-1:0]      sum_in,
	output logic signed [rtmm_pkg::SUM_W-1:0]      sum_out
);
	import rtmm_pkg::*;

	logic signed [VAL_W-1:0]  b_q [DIM];
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [SUM_W-1:0]  sum_q;

	// Column of B, one entry per row
	always_ff @(posedge clk) begin
		if (ctl.b_wr) begin
			b_q[ctl.b_row] <= value;
		end
	end

	// Product stage
	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= value * b_q[ctl.mul_row];
		end
	end

	// Column sum: accumulate, or shift toward the output during drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.shift) begin
			sum_q <= sum_in;
		end else if (ctl.acc_en) begin
			sum_q <= sum_q + SUM_W'(prod_s1);
		end
	end

	assign sum_out = sum_q;

endmodule
